// ----- hdl/lsra_pkg.sv -----
package lsra_pkg;

    localparam int NUM_REGS = 16;
    localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CFG_W    = 5;
    localparam int CNT_W    = ($clog2(NUM_REGS + 1) > CFG_W) ? $clog2(NUM_REGS + 1) : CFG_W;
    localparam int PT_W     = 16;
    localparam int ID_W     = 16;
    localparam int LOC_W    = 16;

    localparam logic [CFG_W-1:0] REG_COUNT_RESET = CFG_W'(16);
    localparam logic [LOC_W-1:0] SLOT_MAX        = '1;

    typedef logic [IDX_W-1:0] reg_idx_t;
    typedef logic [PT_W-1:0]  point_t;
    typedef logic [ID_W-1:0]  value_id_t;

    typedef struct packed {
        logic      starts_function;
        value_id_t value_id;
        point_t    from_point;
        point_t    to_point;
    } in_item_t;

    typedef struct packed {
        value_id_t        assigned_value;
        logic             in_register;
        logic [LOC_W-1:0] location;
        logic             last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT0,
        ST_EMIT1
    } state_t;

    // control from the sequencer to the interval file
    typedef struct packed {
        logic      clear_all;
        logic      expire;
        logic      wr_en;
        reg_idx_t  wr_idx;
        point_t    wr_end;
        value_id_t wr_owner;
    } file_ctrl_t;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic init;
        logic step;
    } scan_ctrl_t;

endpackage

// ----- hdl/linear_scan_register_allocator_core.sv -----
// flow: after an interval is accepted the scan visits each register of the interval file in turn,
// a decide state picks the placement, and the result is loaded into the output register
// a spill gives two results, emitted one after the other; emitting waits while out_ready is low
// a new interval waits until the last result is loaded; in_ready is high only between intervals
// reset: every register free, stack slot counter zero, register_count 16, output empty
module linear_scan_register_allocator_core
    import lsra_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam reg_idx_t LAST_IDX = IDX_W'(NUM_REGS - 1);

    state_t           state_reg,     state_next;
    logic [CFG_W-1:0] count_cfg_reg;
    in_item_t         item_reg,      item_next;
    reg_idx_t         idx_reg,       idx_next;
    logic [LOC_W-1:0] slot_reg,      slot_next;
    logic             two_out_reg,   two_out_next;
    out_item_t        res0_reg,      res0_next;
    out_item_t        res1_reg,      res1_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg,  out_data_next;

    file_ctrl_t       fctl;
    scan_ctrl_t       sctl;
    logic             ent_busy;
    point_t           ent_end;
    value_id_t        ent_owner;
    logic             expire;
    logic             gt;
    logic             free_found;
    reg_idx_t         free_idx;
    logic             vic_found;
    reg_idx_t         vic_idx;
    value_id_t        vic_owner;
    logic [CNT_W-1:0] count_ext;
    logic [CNT_W-1:0] count_eff;
    logic             in_range;
    logic [LOC_W-1:0] slot_inc;

    lsra_file u_file (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (fctl),
        .rd_idx   (idx_reg),
        .rd_busy  (ent_busy),
        .rd_end   (ent_end),
        .rd_owner (ent_owner)
    );

    lsra_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (sctl),
        .idx        (idx_reg),
        .in_range   (in_range),
        .ent_busy   (ent_busy),
        .ent_end    (ent_end),
        .ent_owner  (ent_owner),
        .item_start (item_reg.from_point),
        .item_end   (item_reg.to_point),
        .expire     (expire),
        .gt         (gt),
        .free_found (free_found),
        .free_idx   (free_idx),
        .vic_found  (vic_found),
        .vic_idx    (vic_idx),
        .vic_owner  (vic_owner)
    );

    assign count_ext = CNT_W'(count_cfg_reg);
    assign count_eff = (count_ext > CNT_W'(NUM_REGS)) ? CNT_W'(NUM_REGS) : count_ext;
    assign in_range  = CNT_W'(idx_reg) < count_eff;
    assign slot_inc  = (slot_reg == SLOT_MAX) ? slot_reg : slot_reg + LOC_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_cfg_reg <= REG_COUNT_RESET;
            slot_reg      <= '0;
            two_out_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            two_out_reg   <= two_out_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        res0_reg     <= res0_next;
        res1_reg     <= res1_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        two_out_next   = two_out_reg;
        res0_next      = res0_reg;
        res1_next      = res1_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        fctl           = '0;
        sctl           = '0;
        fctl.wr_end    = item_reg.to_point;
        fctl.wr_owner  = item_reg.value_id;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next      = in_data;
                    idx_next       = '0;
                    sctl.init      = 1'b1;
                    fctl.clear_all = in_data.starts_function;
                    if (in_data.starts_function)
                    begin
                        slot_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                sctl.step   = 1'b1;
                fctl.expire = expire;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_DECIDE:
            begin
                res0_next.assigned_value = item_reg.value_id;
                res1_next.assigned_value = vic_owner;
                res1_next.in_register    = 1'b0;
                res1_next.location       = slot_reg;
                res1_next.last_of_run    = 1'b1;
                two_out_next             = 1'b0;
                if (free_found)
                begin
                    fctl.wr_en            = 1'b1;
                    fctl.wr_idx           = free_idx;
                    res0_next.in_register = 1'b1;
                    res0_next.location    = LOC_W'(free_idx);
                    res0_next.last_of_run = 1'b1;
                end
                else if (vic_found && gt)
                begin
                    // new interval takes the victim's register, victim goes to the stack
                    fctl.wr_en            = 1'b1;
                    fctl.wr_idx           = vic_idx;
                    res0_next.in_register = 1'b1;
                    res0_next.location    = LOC_W'(vic_idx);
                    res0_next.last_of_run = 1'b0;
                    slot_next             = slot_inc;
                    two_out_next          = 1'b1;
                end
                else
                begin
                    res0_next.in_register = 1'b0;
                    res0_next.location    = slot_reg;
                    res0_next.last_of_run = 1'b1;
                    slot_next             = slot_inc;
                end
                state_next = ST_EMIT0;
            end

            ST_EMIT0:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res0_reg;
                    out_valid_next = 1'b1;
                    state_next     = two_out_reg ? ST_EMIT1 : ST_IDLE;
                end
            end

            ST_EMIT1:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res1_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_SCAN)
        else $error("accepted transaction did not start a scan");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |=> state_reg == ST_SCAN || state_reg == ST_DECIDE)
        else $error("scan left to an unexpected state");

    a_spill_first_in_reg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_of_run |-> out_data.in_register)
        else $error("non-final result not placed in a register");

    a_no_expire_and_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(fctl.expire && fctl.wr_en))
        else $error("expire and allocate in the same cycle");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !fctl.wr_en && !sctl.step)
        else $error("ready while the scan unit is busy");

endmodule

// ----- hdl/lsra_file.sv -----
module lsra_file
    import lsra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  file_ctrl_t ctrl,
    input  reg_idx_t   rd_idx,
    output logic       rd_busy,
    output point_t     rd_end,
    output value_id_t  rd_owner
);

    logic [NUM_REGS-1:0] busy_reg;
    point_t              end_reg   [NUM_REGS];
    value_id_t           owner_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (ctrl.clear_all)
        begin
            busy_reg <= '0;
        end
        else
        begin
            if (ctrl.expire)
            begin
                busy_reg[rd_idx] <= 1'b0;
            end
            if (ctrl.wr_en)
            begin
                busy_reg[ctrl.wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            end_reg[ctrl.wr_idx]   <= ctrl.wr_end;
            owner_reg[ctrl.wr_idx] <= ctrl.wr_owner;
        end
    end

    assign rd_busy  = busy_reg[rd_idx];
    assign rd_end   = end_reg[rd_idx];
    assign rd_owner = owner_reg[rd_idx];

endmodule

// ----- hdl/lsra_scan.sv -----
module lsra_scan
    import lsra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scan_ctrl_t ctrl,
    input  reg_idx_t   idx,
    input  logic       in_range,
    input  logic       ent_busy,
    input  point_t     ent_end,
    input  value_id_t  ent_owner,
    input  point_t     item_start,
    input  point_t     item_end,
    output logic       expire,
    output logic       gt,
    output logic       free_found,
    output reg_idx_t   free_idx,
    output logic       vic_found,
    output reg_idx_t   vic_idx,
    output value_id_t  vic_owner
);

    logic      free_found_reg;
    logic      vic_found_reg;
    reg_idx_t  free_idx_reg;
    reg_idx_t  vic_idx_reg;
    point_t    vic_end_reg;
    value_id_t vic_owner_reg;
    logic      live;
    point_t    gt_a;
    point_t    gt_b;

    assign expire = ent_busy && (ent_end <= item_start);
    assign live   = ent_busy && !expire;

    // one magnitude compare: entry vs best victim while scanning, victim vs new end after
    assign gt_a = ctrl.step ? ent_end     : vic_end_reg;
    assign gt_b = ctrl.step ? vic_end_reg : item_end;
    assign gt   = gt_a > gt_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
        end
        else if (ctrl.init)
        begin
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
        end
        else if (ctrl.step && in_range)
        begin
            if (!live)
            begin
                free_found_reg <= 1'b1;
            end
            else if (!vic_found_reg || gt)
            begin
                vic_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step && in_range)
        begin
            if (!live && !free_found_reg)
            begin
                free_idx_reg <= idx;
            end
            // strict compare keeps the lowest register on equal ends
            if (live && (!vic_found_reg || gt))
            begin
                vic_idx_reg   <= idx;
                vic_end_reg   <= ent_end;
                vic_owner_reg <= ent_owner;
            end
        end
    end

    assign free_found = free_found_reg;
    assign free_idx   = free_idx_reg;
    assign vic_found  = vic_found_reg;
    assign vic_idx    = vic_idx_reg;
    assign vic_owner  = vic_owner_reg;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import lsra_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 2 * (NUM_REGS + 4);

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    in_item_t         in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;

    // transactions waiting to be driven, and placements waiting to come out
    in_item_t  pending_intervals[$];
    out_item_t expected_assignments[$];

    logic interval_taken = 1'b0;
    logic steady         = 1'b0;

    // allocator state as the block should hold it
    int unsigned        allowed_regs = 32'(REG_COUNT_RESET);
    logic [NUM_REGS-1:0] live_regs   = '0;
    point_t             live_end [NUM_REGS];
    value_id_t          live_owner [NUM_REGS];
    logic [LOC_W-1:0]   next_slot    = '0;

    int error_count        = 0;
    int intervals_accepted = 0;
    int results_checked    = 0;
    int spill_count        = 0;
    int stack_placements   = 0;
    int cycle_count        = 0;

    linear_scan_register_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [LOC_W-1:0] claim_slot();
        logic [LOC_W-1:0] slot;
        slot = next_slot;
        if (slot != SLOT_MAX)
            next_slot = slot + 1'b1;
        stack_placements++;
        return slot;
    endfunction

    function automatic void predict_placement(input in_item_t item);
        int        limit;
        int        free_idx;
        int        victim;
        out_item_t first;
        out_item_t second;
        limit    = (allowed_regs > NUM_REGS) ? NUM_REGS : int'(allowed_regs);
        free_idx = -1;
        victim   = -1;
        if (item.starts_function)
        begin
            live_regs = '0;
            next_slot = '0;
        end
        // registers above the current count still expire
        for (int r = 0; r < NUM_REGS; r++)
            if (live_regs[r] && live_end[r] <= item.from_point)
                live_regs[r] = 1'b0;
        for (int r = 0; r < limit; r++)
        begin
            if (!live_regs[r])
            begin
                if (free_idx < 0)
                    free_idx = r;
            end
            else if (victim < 0 || live_end[r] > live_end[victim])
                victim = r;
        end
        first.assigned_value = item.value_id;
        first.in_register    = 1'b1;
        first.last_of_run    = 1'b1;
        if (free_idx >= 0)
        begin
            live_regs[free_idx]  = 1'b1;
            live_end[free_idx]   = item.to_point;
            live_owner[free_idx] = item.value_id;
            first.location       = LOC_W'(free_idx);
            expected_assignments.push_back(first);
        end
        else if (victim >= 0 && live_end[victim] > item.to_point)
        begin
            // spill: new value takes the victim's register, victim goes to the stack
            second.assigned_value = live_owner[victim];
            second.in_register    = 1'b0;
            second.location       = claim_slot();
            second.last_of_run    = 1'b1;
            live_end[victim]      = item.to_point;
            live_owner[victim]    = item.value_id;
            first.location        = LOC_W'(victim);
            first.last_of_run     = 1'b0;
            expected_assignments.push_back(first);
            expected_assignments.push_back(second);
            spill_count++;
        end
        else
        begin
            first.in_register = 1'b0;
            first.location    = claim_slot();
            expected_assignments.push_back(first);
        end
    endfunction

    function automatic void check_assignment(input out_item_t got);
        out_item_t want;
        results_checked++;
        if (expected_assignments.size() == 0)
        begin
            $error("unexpected result: assigned_value %0h location %0d",
                   got.assigned_value, got.location);
            error_count++;
            return;
        end
        want = expected_assignments.pop_front();
        if (got.assigned_value !== want.assigned_value)
        begin
            $error("assigned_value: expected %0h, got %0h",
                   want.assigned_value, got.assigned_value);
            error_count++;
        end
        if (got.in_register !== want.in_register)
        begin
            $error("in_register: expected %0b, got %0b", want.in_register, got.in_register);
            error_count++;
        end
        if (got.location !== want.location)
        begin
            $error("location: expected %0d, got %0d", want.location, got.location);
            error_count++;
        end
        if (got.last_of_run !== want.last_of_run)
        begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            error_count++;
        end
    endfunction

    // predictor and monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                allowed_regs = 32'(cfg_data);
            if (in_valid && in_ready)
            begin
                intervals_accepted++;
                predict_placement(in_data);
            end
            interval_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
                check_assignment(out_data);
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || interval_taken)
            begin
                if (pending_intervals.size() != 0 && (steady || $urandom_range(99) >= 22))
                begin
                    in_data  <= pending_intervals.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= steady || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic in_item_t interval(input logic sf, input int unsigned id,
                                          input int unsigned s, input int unsigned e);
        in_item_t item;
        item.starts_function = sf;
        item.value_id        = value_id_t'(id);
        item.from_point      = point_t'(s);
        item.to_point        = point_t'(e);
        return item;
    endfunction

    function automatic void queue_random_intervals(input int n);
        int unsigned cursor;
        int unsigned span;
        int unsigned stop;
        logic        fresh;
        in_item_t    item;
        cursor = 0;
        span   = 1;
        for (int i = 0; i < n; i++)
        begin
            fresh = (i == 0) || ($urandom_range(24) == 0);
            if (fresh)
            begin
                cursor = ($urandom_range(1) == 1) ? $urandom_range(65535) : $urandom_range(200);
                case ($urandom_range(2))
                    0:       span = $urandom_range(6, 1);
                    1:       span = $urandom_range(80, 6);
                    default: span = $urandom_range(5000, 80);
                endcase
            end
            if (!fresh && $urandom_range(9) == 0)
            begin
                // noise: any fields at all, order and bounds ignored
                item = interval(1'($urandom_range(1)), $urandom, $urandom, $urandom);
            end
            else
            begin
                cursor = cursor + $urandom_range(3);
                if (cursor > 65535)
                    cursor = 65535;
                stop = cursor + $urandom_range(span);
                if (stop > 65535)
                    stop = 65535;
                item = interval(fresh, $urandom, cursor, stop);
            end
            pending_intervals.push_back(item);
        end
    endfunction

    task automatic set_register_count(input int unsigned n);
        @(negedge clk);
        cfg_data <= CFG_W'(n);
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_intervals.size() != 0 || in_valid || expected_assignments.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    int unsigned random_counts [9] = '{16, 1, 4, 31, 7, 0, 17, 2, 12};

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // two registers: equal ends, spill on tie, no-spill to stack, expiry,
        // end below start, broken start order, extremes of every field
        set_register_count(2);
        pending_intervals.push_back(interval(1'b1, 16'h0000, 0, 10));
        pending_intervals.push_back(interval(1'b0, 16'hffff, 0, 10));
        pending_intervals.push_back(interval(1'b0, 3, 1, 5));
        pending_intervals.push_back(interval(1'b0, 4, 2, 20));
        pending_intervals.push_back(interval(1'b0, 5, 5, 5));
        pending_intervals.push_back(interval(1'b0, 6, 10, 3));
        pending_intervals.push_back(interval(1'b0, 7, 4, 65535));
        pending_intervals.push_back(interval(1'b0, 8, 4, 65535));
        pending_intervals.push_back(interval(1'b0, 9, 4, 100));
        pending_intervals.push_back(interval(1'b0, 16'ha5a5, 65535, 65535));
        pending_intervals.push_back(interval(1'b1, 16'h5a5a, 0, 0));
        drain();

        // fill four registers, then shrink the count below them
        set_register_count(16);
        pending_intervals.push_back(interval(1'b1, 16'h0100, 0, 50));
        pending_intervals.push_back(interval(1'b0, 16'h0101, 0, 60));
        pending_intervals.push_back(interval(1'b0, 16'h0102, 0, 70));
        pending_intervals.push_back(interval(1'b0, 16'h0103, 0, 80));
        drain();
        set_register_count(2);
        pending_intervals.push_back(interval(1'b0, 16'h0104, 1, 40));
        pending_intervals.push_back(interval(1'b0, 16'h0105, 65, 90));
        pending_intervals.push_back(interval(1'b0, 16'h0106, 66, 66));
        pending_intervals.push_back(interval(1'b0, 16'h0107, 75, 200));
        drain();

        // no registers at all
        set_register_count(0);
        pending_intervals.push_back(interval(1'b0, 16'h0200, 100, 100));
        pending_intervals.push_back(interval(1'b0, 16'h0201, 100, 50));
        drain();

        // count above the built size
        set_register_count(31);
        pending_intervals.push_back(interval(1'b1, 16'hffff, 0, 65535));
        pending_intervals.push_back(interval(1'b0, 16'h0000, 65535, 0));
        drain();

        foreach (random_counts[p])
        begin
            steady <= (p == 2);
            set_register_count(random_counts[p]);
            queue_random_intervals(80);
            drain();
        end
        steady <= 1'b0;

        $display("run covered %0d intervals and %0d checked placements", intervals_accepted,
                 results_checked);
        $display("%0d spills, %0d stack placements, register counts 0 through 31",
                 spill_count, stack_placements);
        if (error_count == 0 && expected_assignments.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
